// File: hdl/brt_pkg.sv
// Shared types, constants and the edge decision for the binary Roberts edge detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package brt_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int EW_W       = COL_W + 1;
    localparam int ROW_W      = 13;
    localparam int REG_W      = 12;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [REG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [REG_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;
    localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;

    typedef struct packed {
        logic             cur;
        logic [COL_W-1:0] addr;
        logic             emit;
        logic             last;
        logic             top_ok;
        logic             bot_ok;
        logic             left_ok;
        logic             right_ok;
    } item_t;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] edge_pixel;
    } result_t;

    // win bit 3*k+t: k = 0 right column .. 2 left column, t = 0 top row .. 2 bottom row
    function automatic logic brt_edge(input logic [8:0] win, input item_t it);
        logic [8:0] mask;
        logic [8:0] p;
        logic [1:0] m [4];
        logic [2:0] a;
        logic [2:0] b;
        mask = 9'h1FF;
        if (!it.top_ok) begin
            mask = mask & ~9'b001_001_001;
        end
        if (!it.bot_ok) begin
            mask = mask & ~9'b100_100_100;
        end
        if (!it.right_ok) begin
            mask = mask & ~9'b000_000_111;
        end
        if (!it.left_ok) begin
            mask = mask & ~9'b111_000_000;
        end
        p = win & mask;
        // centre p[4], right p[1], below p[5], below-right p[2], up-left p[6],
        // up p[3], left p[7], up-right p[0], down-left p[8]
        m[0] = {1'b0, p[4] ^ p[2]} + {1'b0, p[1] ^ p[5]};
        m[1] = {1'b0, p[4] ^ p[6]} + {1'b0, p[3] ^ p[7]};
        m[2] = {1'b0, p[4] ^ p[0]} + {1'b0, p[1] ^ p[3]};
        m[3] = {1'b0, p[4] ^ p[8]} + {1'b0, p[5] ^ p[7]};
        a = '0;
        b = '0;
        for (int i = 0; i < 4; i++) begin
            if (m[i] == 2'd2) begin
                b = b + 3'd1;
            end else if (m[i] == 2'd1) begin
                a = a + 3'd1;
            end
        end
        return (b >= 3'd2) || (b == 3'd1 && a >= 3'd1) || (b == 3'd0 && a >= 3'd3);
    endfunction

endpackage

`default_nettype wire

// File: hdl/brt_front.sv
// Front end: configuration registers, raster counters and classification of each pixel.
// Depends on brt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brt_front (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_valid,
    input  wire  [brt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [brt_pkg::REG_W-1:0]    cfg_data,
    input  wire                          accept,
    input  wire  [brt_pkg::PIX_W-1:0]    pixel,
    input  wire                          flush,
    output logic [brt_pkg::COL_W-1:0]    rd_addr,
    output logic                         item_valid,
    output brt_pkg::item_t               item
);
    import brt_pkg::*;

    logic [REG_W-1:0] image_width_reg;
    logic [REG_W-1:0] image_height_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             item_valid_reg;
    item_t            item_reg, item_next;

    logic [EW_W-1:0]  w;
    logic [REG_W-1:0] h;
    logic [ROW_W-1:0] hx;
    logic [COL_W-1:0] ci;
    logic [ROW_W-1:0] ri;
    logic [ROW_W-1:0] r;
    logic [EW_W-1:0]  ci_inc;
    logic             ci_nz;
    logic             no_row;
    logic             past;
    logic [COL_W-1:0] adv_col;
    logic [ROW_W-1:0] adv_row;

    always_comb begin
        if (image_width_reg == '0) begin
            w = EW_W'(1);
        end else if (32'(image_width_reg) > 32'(MAX_WIDTH)) begin
            w = EW_W'(MAX_WIDTH);
        end else begin
            w = EW_W'(image_width_reg);
        end
        h  = (image_height_reg == '0) ? REG_W'(1) : image_height_reg;
        hx = ROW_W'(h);

        if (EW_W'(col_reg) >= w) begin
            ci = '0;
            ri = row_reg + ROW_W'(1);
        end else begin
            ci = col_reg;
            ri = row_reg;
        end
        ci_nz  = (ci != '0);
        no_row = ci_nz ? (ri == '0) : (ri < ROW_W'(2));
        past   = ci_nz ? (ri >= hx + ROW_W'(1)) : (ri >= hx + ROW_W'(2));
        r      = ci_nz ? (ri - ROW_W'(1)) : (ri - ROW_W'(2));

        item_next.cur      = !flush && (pixel == PIX_BLACK);
        item_next.addr     = ci;
        item_next.emit     = !no_row && !past;
        item_next.last     = !ci_nz && (r == hx - ROW_W'(1));
        item_next.top_ok   = (r != '0);
        item_next.bot_ok   = (r + ROW_W'(1)) < hx;
        item_next.left_ok  = ci_nz ? (ci >= COL_W'(2)) : (w >= EW_W'(2));
        item_next.right_ok = ci_nz;

        ci_inc = EW_W'(ci) + EW_W'(1);
        if (ci_inc >= w) begin
            adv_col = '0;
            adv_row = ri + ROW_W'(1);
        end else begin
            adv_col = ci_inc[COL_W-1:0];
            adv_row = ri;
        end

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (no_row) begin
                col_next = adv_col;
                row_next = adv_row;
            end else if (past || item_next.last) begin
                col_next = '0;
                row_next = '0;
            end else begin
                col_next = adv_col;
                row_next = adv_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            item_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                    CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    default: ;
                endcase
            end
            col_reg        <= col_next;
            row_reg        <= row_next;
            item_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign rd_addr    = ci;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: hdl/brt_linebuf.sv
// Two one-bit line buffers held as one 2-bit wide memory with registered read and bypass.
// Depends on brt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brt_linebuf (
    input  wire                       aclk,
    input  wire                       rd_en,
    input  wire  [brt_pkg::COL_W-1:0] rd_addr,
    input  wire                       wr_en,
    input  wire  [brt_pkg::COL_W-1:0] wr_addr,
    input  wire  [1:0]                wr_data,
    output logic [1:0]                rd_data
);
    import brt_pkg::*;

    // bit 1: older row, bit 0: newer row
    logic [1:0] mem [MAX_WIDTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/brt_back.sv
// Back end: 3x3 window shift, line buffer write-back and edge decision per centre pixel.
// Depends on brt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brt_back (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       item_valid,
    input  wire  brt_pkg::item_t      item,
    input  wire  [1:0]                rd_data,
    output logic                      wr_en,
    output logic [brt_pkg::COL_W-1:0] wr_addr,
    output logic [1:0]                wr_data,
    output logic                      push,
    output brt_pkg::result_t          push_data
);
    import brt_pkg::*;

    logic [8:0] window_reg, window_next;
    logic [2:0] col;

    always_comb begin
        col         = {item.cur, rd_data[0], rd_data[1]};
        window_next = {window_reg[5:0], col};
        wr_en       = item_valid;
        wr_addr     = item.addr;
        wr_data     = {rd_data[0], item.cur};
        push        = item_valid && item.emit;
        push_data.last       = item.last;
        push_data.edge_pixel = brt_edge(window_next, item) ? PIX_BLACK : PIX_WHITE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (item_valid) begin
            window_reg <= window_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/brt_fifo.sv
// Result queue between the back end and the output channel.
// Depends on brt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brt_fifo (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            push,
    input  wire  brt_pkg::result_t         push_data,
    output logic [brt_pkg::FIFO_CNT_W-1:0] count,
    output logic                           out_valid,
    input  wire                            out_ready,
    output brt_pkg::result_t               out_data
);
    import brt_pkg::*;

    result_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    pop;

    assign pop = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign count     = count_reg;
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: hdl/binary_roberts_edge_detect.sv
// Binary Roberts cross edge detector: top level joining front end, line buffer,
// back end and result queue. Depends on brt_pkg, brt_front, brt_linebuf, brt_back and brt_fifo.
//
// Usage:
//   s_ channel: one grayscale pixel per transaction in raster order (tdata = pixel,
//   tuser = flush). After each frame feed image_width+1 flush transactions to drain
//   the last row. m_ channel: one edge pixel (0 = edge, 255 = none) per centre pixel,
//   tlast on the final pixel of the frame. cfg_ channel: register writes, index 0 =
//   image_width, 1 = image_height; write only while the block is idle.
//   Throughput: one pixel per clock while s_tready is high, set by the line buffer's
//   single read and write port per cycle. A result passes the front register and the
//   line buffer read, then the window logic, and is registered in the result queue.
//   The first image_width+1 pixels of a frame give no result.
//   Reset: synchronous, active low; counters, window and queue clear, registers return
//   to 640 x 480. The line buffer is not cleared; stale entries are masked.
//   Stall: a four-entry result queue absorbs output stalls; s_tready drops once
//   queued plus in-flight results would fill it.
`timescale 1ns / 1ps
`default_nettype none

module binary_roberts_edge_detect (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [7:0]                     s_tdata,   // [7:0] pixel
    input  wire                            s_tuser,   // [0] flush
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] edge_pixel
    output logic                           m_tlast,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [brt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [brt_pkg::REG_W-1:0]      cfg_data
);
    import brt_pkg::*;

    logic                  accept;
    logic [COL_W-1:0]      rd_addr;
    logic                  item_valid;
    item_t                 item;
    logic [1:0]            rd_data;
    logic                  wr_en;
    logic [COL_W-1:0]      wr_addr;
    logic [1:0]            wr_data;
    logic                  push;
    result_t               push_data;
    logic [FIFO_CNT_W-1:0] count;
    result_t               out_data;

    assign s_tready  = (32'(count) + 32'(item_valid)) < FIFO_DEPTH;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    brt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .pixel      (s_tdata),
        .flush      (s_tuser),
        .rd_addr    (rd_addr),
        .item_valid (item_valid),
        .item       (item)
    );

    brt_linebuf u_linebuf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    brt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .push       (push),
        .push_data  (push_data)
    );

    brt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .count     (count),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = out_data.edge_pixel;
    assign m_tlast = out_data.last;

endmodule

`default_nettype wire

// File: hdl/brt_checker.sv
// Port-level checks for binary_roberts_edge_detect, attached by bind.
// Depends on brt_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module brt_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [7:0]                     m_tdata,
    input wire                           m_tlast
);
    import brt_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    a_out_binary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == PIX_BLACK || m_tdata == PIX_WHITE))
        else $error("edge pixel neither black nor white");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present right after reset");

    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result appeared without an input transaction two clocks before");

endmodule

bind binary_roberts_edge_detect brt_checker u_brt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for binary_roberts_edge_detect: streams pixel frames under
// several image sizes and checks every edge pixel against a bit-level window predictor.
// Depends on brt_pkg and the binary_roberts_edge_detect RTL.

module tb_top;
    import brt_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_GAP       = 13;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 330;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int MAX_PRINTED   = 40;

    localparam bit IMAGE = 1'b0;
    localparam bit DRAIN = 1'b1;

    typedef struct {
        bit [PIX_W-1:0] pix;
        bit             is_last;
    } edge_pixel_t;

    class edge_map_scoreboard;
        bit [REG_W-1:0] width_reg;
        bit [REG_W-1:0] height_reg;
        bit             older_line [MAX_WIDTH];
        bit             newer_line [MAX_WIDTH];
        bit [8:0]       win;
        int             col;
        int             row;
        edge_pixel_t    expected_edges [$];
        int             errors;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (older_line[i]) begin
                older_line[i] = 1'b0;
                newer_line[i] = 1'b0;
            end
            win    = '0;
            col    = 0;
            row    = 0;
            errors = 0;
        endfunction

        function void report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("ERROR at %0t: %s", $time, msg);
            end
        endfunction

        function int pending();
            return expected_edges.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, bit [REG_W-1:0] value);
            if (idx == CFG_IMAGE_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
        endfunction

        // window bit 3*k+t: k = 0 newest column (c+1) .. 2 oldest, t = 0 row above .. 2 below
        function bit neighbor(int r, int c, int dr, int dc, int w, int h);
            int rr;
            int cc;
            rr = r + dr;
            cc = c + dc;
            if (rr < 0 || rr >= h || cc < 0 || cc >= w) begin
                return 1'b0;
            end
            return win[3 * (1 - dc) + (1 + dr)];
        endfunction

        function void advance(int w);
            col++;
            if (col >= w) begin
                col = 0;
                row++;
            end
        endfunction

        function void note_input(bit [PIX_W-1:0] pix, bit flush);
            int          w;
            int          h;
            int          r;
            int          c;
            int          a;
            int          b;
            bit          cur;
            bit          top;
            bit          mid;
            bit          is_edge;
            bit [8:0]    p;
            bit [1:0]    m [4];
            edge_pixel_t res;
            w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
            h = (height_reg == 0) ? 1 : int'(height_reg);
            cur = (flush == IMAGE) && (pix == PIX_BLACK);
            if (col >= w) begin
                col = 0;
                row++;
            end
            top = older_line[col];
            mid = newer_line[col];
            older_line[col] = mid;
            newer_line[col] = cur;
            win = {win[5:0], cur, mid, top};
            if (col >= 1) begin
                r = row - 1;
                c = col - 1;
            end else begin
                r = row - 2;
                c = w - 1;
            end
            if (r < 0) begin
                advance(w);
                return;
            end
            if (r >= h) begin
                col = 0;
                row = 0;
                return;
            end
            p[0] = neighbor(r, c,  0,  0, w, h);
            p[1] = neighbor(r, c,  0,  1, w, h);
            p[2] = neighbor(r, c,  1,  0, w, h);
            p[3] = neighbor(r, c,  1,  1, w, h);
            p[4] = neighbor(r, c, -1, -1, w, h);
            p[5] = neighbor(r, c, -1,  0, w, h);
            p[6] = neighbor(r, c,  0, -1, w, h);
            p[7] = neighbor(r, c, -1,  1, w, h);
            p[8] = neighbor(r, c,  1, -1, w, h);
            m[0] = {1'b0, p[0] ^ p[3]} + {1'b0, p[1] ^ p[2]};
            m[1] = {1'b0, p[0] ^ p[4]} + {1'b0, p[5] ^ p[6]};
            m[2] = {1'b0, p[0] ^ p[7]} + {1'b0, p[1] ^ p[5]};
            m[3] = {1'b0, p[0] ^ p[8]} + {1'b0, p[2] ^ p[6]};
            a = 0;
            b = 0;
            for (int i = 0; i < 4; i++) begin
                if (m[i] == 2'd2) begin
                    b++;
                end else if (m[i] == 2'd1) begin
                    a++;
                end
            end
            is_edge = (b >= 2) || (b == 1 && a >= 1) || (b == 0 && a >= 3);
            res.pix     = is_edge ? PIX_BLACK : PIX_WHITE;
            res.is_last = (r == h - 1) && (c == w - 1);
            expected_edges.push_back(res);
            if (res.is_last) begin
                col = 0;
                row = 0;
            end else begin
                advance(w);
            end
        endfunction

        function void check_result(bit [PIX_W-1:0] pix, bit is_last);
            edge_pixel_t want;
            if (expected_edges.size() == 0) begin
                report_mismatch($sformatf("unexpected result pixel=%0d last=%0b", pix, is_last));
                return;
            end
            want = expected_edges.pop_front();
            if (pix != want.pix) begin
                report_mismatch($sformatf("edge_pixel %0d, predicted %0d", pix, want.pix));
            end
            if (is_last != want.is_last) begin
                report_mismatch($sformatf("last %0b, predicted %0b", is_last, want.is_last));
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [PIX_W-1:0]     m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data  = '0;

    edge_map_scoreboard sb;
    int unsigned        cycle_count = 0;
    int                 random_items = 0;
    bit                 s_burst = 1'b0;
    bit                 m_burst = 1'b0;
    bit                 hold_req = 1'b0;

    binary_roberts_edge_detect dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("binary_roberts_edge_detect: mismatch");
            $finish;
        end
    end

    function automatic int draw_gap(bit burst);
        return burst ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic bit [PIX_W-1:0] draw_pixel(int black_pct);
        if ($urandom_range(0, 99) < black_pct) begin
            return PIX_BLACK;
        end
        return PIX_W'($urandom_range(1, 255));
    endfunction

    task automatic send_item(input bit [PIX_W-1:0] pix, input bit flush);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            s_burst = !s_burst;
        end
        gap = draw_gap(s_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= flush;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(pix, flush);
    endtask

    // drop valid, drain every predicted result, then let the pipeline empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame_size(input int w, input int h);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= REG_W'(w);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_register(CFG_IMAGE_WIDTH, REG_W'(w));
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= REG_W'(h);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_register(CFG_IMAGE_HEIGHT, REG_W'(h));
        cfg_valid <= 1'b0;
    endtask

    // one frame plus its drain; noisy frames get stray flush transactions and broken drains
    task automatic send_frame(input int w, input int h, input int black_pct, input bit noisy);
        int drain_len;
        for (int i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(0, 19) == 0) begin
                send_item(draw_pixel(black_pct), DRAIN);
            end else begin
                send_item(draw_pixel(black_pct), IMAGE);
            end
        end
        drain_len = w + 1;
        if (noisy && $urandom_range(0, 5) == 0) begin
            drain_len = $urandom_range(0, w + 2);
        end
        for (int i = 0; i < drain_len; i++) begin
            if (noisy && $urandom_range(0, 15) == 0) begin
                send_item(draw_pixel(black_pct), IMAGE);
            end else begin
                send_item(draw_pixel(50), DRAIN);
            end
        end
        random_items += w * h + drain_len;
    endtask

    initial begin : result_sink
        int gap;
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                m_burst = !m_burst;
            end
            gap = hold_req ? HOLD_CYCLES : draw_gap(m_burst);
            hold_req = 1'b0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_result(m_tdata, m_tlast);
        end
    end

    initial begin : stimulus
        int w;
        int h;
        int pct;
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // byte extremes, flush over a black byte, black byte during the drain
        set_frame_size(3, 3);
        send_item(8'd0, IMAGE);
        send_item(8'd255, IMAGE);
        send_item(8'd0, IMAGE);
        send_item(8'd1, IMAGE);
        send_item(8'd0, DRAIN);
        send_item(8'd0, IMAGE);
        send_item(8'd128, IMAGE);
        send_item(8'd0, IMAGE);
        send_item(8'd127, IMAGE);
        send_item(8'd255, DRAIN);
        send_item(8'd0, IMAGE);
        send_item(8'd0, DRAIN);
        send_item(8'd254, DRAIN);

        set_frame_size(1, 1);
        send_item(8'd0, IMAGE);
        send_item(8'd0, DRAIN);
        send_item(8'd85, DRAIN);

        set_frame_size(2, 2);
        repeat (4) send_item(8'd0, IMAGE);
        repeat (3) send_item(8'd170, DRAIN);

        // zero sizes clamp to one
        set_frame_size(0, 0);
        repeat (3) send_frame(1, 1, 50, 1'b0);

        // width above the maximum clamps; leave the frame open
        set_frame_size(4095, 4095);
        repeat (8) send_item(draw_pixel(50), IMAGE);

        // size change mid-frame: column wrap, then rows past the new last row
        set_frame_size(5, 4);
        repeat (9) send_item(draw_pixel(50), IMAGE);
        set_frame_size(3, 4);
        repeat (6) send_item(draw_pixel(50), IMAGE);
        set_frame_size(3, 2);
        repeat (12) send_item(draw_pixel(50), IMAGE);

        // receiver holds off while a whole frame is sent, so the full result queue stalls the input
        set_frame_size(8, 6);
        hold_req = 1'b1;
        send_frame(8, 6, 45, 1'b0);

        random_items = 0;
        hold_req = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_frame_size(w, h);
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 2))
                    0: pct = 10;
                    1: pct = 45;
                    default: pct = 80;
                endcase
                send_frame(w, h, pct, $urandom_range(0, 2) == 0);
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("binary_roberts_edge_detect: match");
        end else begin
            $display("binary_roberts_edge_detect: mismatch");
        end
        $finish;
    end

endmodule
